### rtl/usb_control_transfer_stage_fsm_assert.svh
// assertion macros shared by the control transfer stage sequencer
`ifndef USB_CONTROL_TRANSFER_STAGE_FSM_ASSERT_SVH
`define USB_CONTROL_TRANSFER_STAGE_FSM_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define UCTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ucts assertion failed");
// condition must never be seen out of reset
`define UCTS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ucts forbidden condition seen");
`else
`define UCTS_ASSERT(lbl, prop)
`define UCTS_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/ucts_pkg.sv
// types and constants of the control transfer stage sequencer
package ucts_pkg;

    localparam int LEN_W = 16;
    localparam int MPS_W = 7;
    localparam logic [MPS_W-1:0] MPS_MIN = 7'd8;
    localparam logic [MPS_W-1:0] MPS_MAX = 7'd64;
    localparam logic [MPS_W-1:0] MPS_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_BUS_RESET   = 3'd0,
        OP_SETUP_RX    = 3'd1,
        OP_OUT_RX      = 3'd2,
        OP_TX_DONE     = 3'd3,
        OP_START_IN    = 3'd4,
        OP_START_OUT   = 3'd5,
        OP_STATUS_REQ  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND       = 3'd1,
        ACT_ARM_RX     = 3'd2,
        ACT_ARM_ZLP_RX = 3'd3,
        ACT_STALL      = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        NTF_NONE       = 3'd0,
        NTF_SETUP      = 3'd1,
        NTF_STATUS_IN  = 3'd2,
        NTF_STATUS_OUT = 3'd3,
        NTF_DATA_IN    = 3'd4,
        NTF_DATA_OUT   = 3'd5
    } notify_t;

    typedef enum logic [2:0] {
        ST_SETUP        = 3'd0,
        ST_DATA_OUT     = 3'd1,
        ST_DATA_IN      = 3'd2,
        ST_DATA_IN_LAST = 3'd3,
        ST_STATUS_IN    = 3'd4,
        ST_STATUS_OUT   = 3'd5
    } stage_t;

    typedef struct packed {
        op_t              op;
        logic [MPS_W-1:0] rx_bytes;
        logic [LEN_W-1:0] xfer_length;
        logic [LEN_W-1:0] buffer_base;
        logic             success;
    } req_t;

    typedef struct packed {
        action_t          action;
        logic [LEN_W-1:0] tx_address;
        logic [MPS_W-1:0] tx_length;
        logic [LEN_W-1:0] rx_address;
        logic [MPS_W-1:0] rx_count;
        notify_t          notify;
        logic [LEN_W-1:0] out_total;
        logic             protocol_error;
    } result_t;

endpackage

### rtl/ucts_in_reg.sv
// input request register with stall toward the sender
module ucts_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ucts_pkg::req_t in_req,
    input  logic          adv,
    output logic          req_valid,
    output ucts_pkg::req_t req
);
    import ucts_pkg::*;

    logic   vld_reg, vld_next;
    req_t   req_reg;
    logic   load;

    // full and not draining this cycle
    assign in_stall = vld_reg && !adv;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (adv)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = vld_reg;
    assign req       = req_reg;

endmodule

### rtl/ucts_step.sv
// stage state machine, transfer counters and packet size register
`include "usb_control_transfer_stage_fsm_assert.svh"
module ucts_step (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [ucts_pkg::MPS_W-1:0] cfg_wr_data,
    input  logic                     adv,
    input  ucts_pkg::req_t           req,
    output ucts_pkg::result_t        res
);
    import ucts_pkg::*;

    logic [MPS_W-1:0] mps_reg, mps_next;
    stage_t           stage_reg, stage_next;
    logic [LEN_W-1:0] dp_reg, dp_next;
    logic [LEN_W-1:0] bl_reg, bl_next;
    logic [LEN_W-1:0] exp_reg, exp_next;

    logic             err;
    logic [LEN_W-1:0] mps_w, rxb_w, use_w, bl_out, in_n;
    logic             in_short;

    assign mps_w    = LEN_W'(mps_reg);
    assign rxb_w    = LEN_W'(req.rx_bytes);
    // bytes stored from an out packet
    assign use_w    = (rxb_w < bl_reg) ? rxb_w : bl_reg;
    assign bl_out   = bl_reg - use_w;
    // remainder is shorter than one packet (zero included)
    assign in_short = (bl_reg < mps_w);
    assign in_n     = (bl_reg <= mps_w) ? bl_reg : mps_w;

    // saturate packet size writes
    always_comb
    begin
        mps_next = mps_reg;
        if (cfg_wr_en)
        begin
            priority if (cfg_wr_data < MPS_MIN)
            begin
                mps_next = MPS_MIN;
            end
            else if (cfg_wr_data > MPS_MAX)
            begin
                mps_next = MPS_MAX;
            end
            else
            begin
                mps_next = cfg_wr_data;
            end
        end
    end

    // legality of the event in the current stage
    always_comb
    begin
        unique case (req.op)
            OP_BUS_RESET, OP_SETUP_RX: err = 1'b0;
            OP_OUT_RX:     err = !(stage_reg == ST_DATA_OUT || stage_reg == ST_STATUS_IN);
            OP_TX_DONE:    err = !(stage_reg == ST_DATA_IN || stage_reg == ST_DATA_IN_LAST
                                   || stage_reg == ST_STATUS_OUT);
            OP_START_IN,
            OP_START_OUT:  err = (stage_reg != ST_SETUP);
            OP_STATUS_REQ: err = !(stage_reg == ST_SETUP || stage_reg == ST_DATA_OUT);
            default:       err = 1'b1;
        endcase
    end

    // next stage
    always_comb
    begin
        stage_next = stage_reg;
        if (!err)
        begin
            unique case (req.op)
                OP_BUS_RESET, OP_SETUP_RX: stage_next = ST_SETUP;
                OP_OUT_RX:
                begin
                    if (stage_reg == ST_STATUS_IN)
                    begin
                        stage_next = ST_SETUP;
                    end
                end
                OP_TX_DONE:
                begin
                    unique case (stage_reg)
                        ST_DATA_IN:      stage_next = in_short ? ST_DATA_IN_LAST : ST_DATA_IN;
                        ST_DATA_IN_LAST: stage_next = ST_STATUS_IN;
                        default:         stage_next = ST_SETUP;
                    endcase
                end
                OP_START_IN:
                    stage_next = (req.xfer_length < mps_w) ? ST_DATA_IN_LAST : ST_DATA_IN;
                OP_START_OUT:  stage_next = ST_DATA_OUT;
                OP_STATUS_REQ: stage_next = req.success ? ST_STATUS_OUT : ST_SETUP;
                default:       stage_next = stage_reg;
            endcase
        end
    end

    // result and counter updates
    always_comb
    begin
        res      = '0;
        dp_next  = dp_reg;
        bl_next  = bl_reg;
        exp_next = exp_reg;
        if (err)
        begin
            res.protocol_error = 1'b1;
        end
        else
        begin
            unique case (req.op)
                OP_BUS_RESET, OP_SETUP_RX:
                begin
                    dp_next  = '0;
                    bl_next  = '0;
                    exp_next = '0;
                    if (req.op == OP_BUS_RESET)
                    begin
                        res.action = ACT_ARM_RX;
                    end
                    else
                    begin
                        res.notify = NTF_SETUP;
                    end
                end
                OP_OUT_RX:
                begin
                    if (stage_reg == ST_STATUS_IN)
                    begin
                        res.action = ACT_ARM_RX;
                        res.notify = NTF_STATUS_IN;
                    end
                    else
                    begin
                        res.rx_address = dp_reg;
                        res.rx_count   = MPS_W'(use_w);
                        bl_next        = bl_out;
                        dp_next        = dp_reg + use_w;
                        // short packet or all expected bytes in
                        if (req.rx_bytes < mps_reg || bl_out == '0)
                        begin
                            res.notify    = NTF_DATA_OUT;
                            res.out_total = exp_reg - bl_out;
                        end
                        else
                        begin
                            res.action = ACT_ARM_RX;
                        end
                    end
                end
                OP_TX_DONE:
                begin
                    unique case (stage_reg)
                        ST_DATA_IN:
                        begin
                            res.action     = ACT_SEND;
                            res.tx_length  = MPS_W'(in_n);
                            res.tx_address = (in_n != '0) ? dp_reg : '0;
                            dp_next        = dp_reg + in_n;
                            bl_next        = bl_reg - in_n;
                        end
                        ST_DATA_IN_LAST:
                        begin
                            res.action = ACT_ARM_ZLP_RX;
                            res.notify = NTF_DATA_IN;
                        end
                        default:
                        begin
                            res.action = ACT_ARM_RX;
                            res.notify = NTF_STATUS_OUT;
                        end
                    endcase
                end
                OP_START_IN:
                begin
                    exp_next   = req.xfer_length;
                    res.action = ACT_SEND;
                    if (req.xfer_length <= mps_w)
                    begin
                        bl_next        = '0;
                        res.tx_length  = MPS_W'(req.xfer_length);
                        res.tx_address = (req.xfer_length != '0) ? req.buffer_base : '0;
                        dp_next        = req.buffer_base + req.xfer_length;
                    end
                    else
                    begin
                        bl_next        = req.xfer_length - mps_w;
                        res.tx_length  = mps_reg;
                        res.tx_address = req.buffer_base;
                        dp_next        = req.buffer_base + mps_w;
                    end
                end
                OP_START_OUT:
                begin
                    exp_next   = req.xfer_length;
                    bl_next    = req.xfer_length;
                    dp_next    = req.buffer_base;
                    res.action = ACT_ARM_RX;
                end
                OP_STATUS_REQ:
                begin
                    res.action = req.success ? ACT_SEND : ACT_STALL;
                end
                default:
                begin
                    res.protocol_error = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mps_reg   <= MPS_RESET;
            stage_reg <= ST_SETUP;
            dp_reg    <= '0;
            bl_reg    <= '0;
            exp_reg   <= '0;
        end
        else
        begin
            mps_reg <= mps_next;
            if (adv)
            begin
                stage_reg <= stage_next;
                dp_reg    <= dp_next;
                bl_reg    <= bl_next;
                exp_reg   <= exp_next;
            end
        end
    end

    `UCTS_ASSERT(a_mps_range, mps_reg >= MPS_MIN && mps_reg <= MPS_MAX)
    `UCTS_ASSERT(a_err_holds, adv && err |=> $stable(stage_reg) && $stable(bl_reg) && $stable(dp_reg))
    `UCTS_ASSERT(a_reset_clears, adv && req.op == OP_BUS_RESET |=> stage_reg == ST_SETUP && bl_reg == '0)
    `UCTS_ASSERT_NEVER(a_err_quiet, res.protocol_error && (res.action != ACT_NONE || res.notify != NTF_NONE))

endmodule

### rtl/ucts_out_reg.sv
// result register with stall from the receiver
module ucts_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  ucts_pkg::result_t res,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output ucts_pkg::result_t out_res
);
    import ucts_pkg::*;

    logic    vld_reg, vld_next;
    result_t res_reg;

    // empty, or the held result leaves this cycle
    assign out_free = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

### rtl/usb_control_transfer_stage_fsm.sv
// top level of the device-side usb control endpoint stage sequencer
//
// Takes one endpoint event request per cycle while in_stall is low (bus reset,
// setup, out packet, in packet sent, start data in, start data out, status)
// and returns exactly one result per request: an endpoint action, an
// upper-layer notification and a protocol error flag. Throughput is one
// request per clock cycle when neither side stalls; a request is held in the
// request register and then in the result register, which presents it. The
// stage, buffer pointer, bytes left and expected total update as the request
// moves from the request register into the result register, so a following
// request sees them at once. The user must write the packet size register
// through cfg_wr_en / cfg_wr_data only while no request is pending; the block
// does not enforce this. Values are clamped to 8..64 and reset to 64.
module usb_control_transfer_stage_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [ucts_pkg::MPS_W-1:0] cfg_wr_data,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 op,
    input  logic [ucts_pkg::MPS_W-1:0] rx_bytes,
    input  logic [ucts_pkg::LEN_W-1:0] xfer_length,
    input  logic [ucts_pkg::LEN_W-1:0] buffer_base,
    input  logic                       success,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 action,
    output logic [ucts_pkg::LEN_W-1:0] tx_address,
    output logic [ucts_pkg::MPS_W-1:0] tx_length,
    output logic [ucts_pkg::LEN_W-1:0] rx_address,
    output logic [ucts_pkg::MPS_W-1:0] rx_count,
    output logic [2:0]                 notify,
    output logic [ucts_pkg::LEN_W-1:0] out_total,
    output logic                       protocol_error
);
    import ucts_pkg::*;

    req_t    in_req;
    req_t    req;
    logic    req_valid;
    logic    out_free;
    logic    adv;
    result_t res;
    result_t out_res;

    // pack the request fields
    assign in_req.op          = op_t'(op);
    assign in_req.rx_bytes    = rx_bytes;
    assign in_req.xfer_length = xfer_length;
    assign in_req.buffer_base = buffer_base;
    assign in_req.success     = success;

    // a held request moves on when the result slot can take it
    assign adv = req_valid && out_free;

    ucts_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req)
    );

    // stage logic and state
    ucts_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .adv         (adv),
        .req         (req),
        .res         (res)
    );

    ucts_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // unpack the result fields
    assign action         = out_res.action;
    assign tx_address     = out_res.tx_address;
    assign tx_length      = out_res.tx_length;
    assign rx_address     = out_res.rx_address;
    assign rx_count       = out_res.rx_count;
    assign notify         = out_res.notify;
    assign out_total      = out_res.out_total;
    assign protocol_error = out_res.protocol_error;

endmodule
